// ===== hdl/sbr_pkg.sv =====
`timescale 1ns / 1ps

package sbr_pkg;

  // One beat of the request side: a payload byte and the sender's details.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        addr_is_v6;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [15:0] src_port;
  } sbr_req_t;

  // One beat of the response side.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } sbr_resp_t;

  localparam int unsigned CountW = 5;
  localparam int unsigned HdrAddrW = 5;
  localparam int unsigned PosW = 6;
  localparam int unsigned HdrDepth = 20;

  localparam logic [CountW-1:0] HdrLastIdx = 5'd19;
  localparam logic [CountW-1:0] HdrLenC = 5'd20;
  localparam logic [CountW-1:0] CountMax = 5'd31;

  localparam logic [31:0] MagicCookie = 32'h2112A442;
  localparam logic [15:0] ReqType = 16'h0001;
  localparam logic [15:0] RespType = 16'h0101;
  localparam logic [15:0] AttrXorMapped = 16'h0020;
  localparam logic [7:0]  FamV4 = 8'h01;
  localparam logic [7:0]  FamV6 = 8'h02;
  localparam logic [7:0]  MsgLenV4 = 8'd12;
  localparam logic [7:0]  MsgLenV6 = 8'd24;
  localparam logic [7:0]  AttrLenV4 = 8'd8;
  localparam logic [7:0]  AttrLenV6 = 8'd20;

  // Byte positions within the response.
  localparam logic [PosW-1:0] PosTxnFirst = 6'd8;
  localparam logic [PosW-1:0] PosAttrFirst = 6'd20;
  localparam logic [PosW-1:0] PosAddrFirst = 6'd28;
  localparam logic [PosW-1:0] PosMaskTxn = 6'd32;
  localparam logic [PosW-1:0] PosTxnToMask = 6'd24;
  localparam logic [PosW-1:0] PosLastV4 = 6'd31;
  localparam logic [PosW-1:0] PosLastV6 = 6'd43;

  // Checks one request header byte against the expected type and cookie.
  function automatic logic hdr_byte_ok(logic [CountW-1:0] idx, logic [7:0] b);
    logic ok;
    case (idx)
      5'd0:    ok = (b == ReqType[15:8]);
      5'd1:    ok = (b == ReqType[7:0]);
      5'd4:    ok = (b == MagicCookie[31:24]);
      5'd5:    ok = (b == MagicCookie[23:16]);
      5'd6:    ok = (b == MagicCookie[15:8]);
      5'd7:    ok = (b == MagicCookie[7:0]);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  // Builds the response byte at a given position. The header byte read from
  // the store is only meaningful where the position takes a transaction id
  // byte, either directly or as part of the IPv6 mask.
  function automatic logic [7:0] resp_byte(logic [PosW-1:0] pos, logic v6,
                                           logic [127:0] addr, logic [15:0] port,
                                           logic [7:0] hdr);
    logic [3:0] j;
    logic [7:0] a;
    logic [7:0] m;
    logic [7:0] b;
    j = 4'(pos - PosAddrFirst);
    a = v6 ? addr[8*(15-j) +: 8] : addr[8*(3-j[1:0]) +: 8];
    m = (!v6 || (j < 4'd4)) ? MagicCookie[8*(3-j[1:0]) +: 8] : hdr;
    if (pos >= PosAddrFirst) begin
      b = a ^ m;
    end else if ((pos >= PosTxnFirst) && (pos < PosAttrFirst)) begin
      b = hdr;
    end else begin
      case (pos)
        6'd0:    b = RespType[15:8];
        6'd1:    b = RespType[7:0];
        6'd3:    b = v6 ? MsgLenV6 : MsgLenV4;
        6'd4:    b = MagicCookie[31:24];
        6'd5:    b = MagicCookie[23:16];
        6'd6:    b = MagicCookie[15:8];
        6'd7:    b = MagicCookie[7:0];
        6'd20:   b = AttrXorMapped[15:8];
        6'd21:   b = AttrXorMapped[7:0];
        6'd23:   b = v6 ? AttrLenV6 : AttrLenV4;
        6'd25:   b = v6 ? FamV6 : FamV4;
        6'd26:   b = port[15:8] ^ MagicCookie[31:24];
        6'd27:   b = port[7:0] ^ MagicCookie[23:16];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== hdl/sbr_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module sbr_ram #(
  parameter int Width = 8,
  parameter int Depth = 20,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/stun_binding_responder.sv =====
`timescale 1ns / 1ps

// STUN Binding responder.
// The request channel carries the UDP payload of a request, one byte per
// beat, with the sender's family, address and port alongside; last_byte marks
// the final beat of a packet. The first 20 bytes are written into a small
// header RAM and the type and cookie are checked as they arrive.
// When the last beat of a valid Binding Request (at least 20 bytes, type
// 0x0001, the magic cookie) is accepted, a Binding Success response of 32
// bytes (IPv4) or 44 bytes (IPv6) is sent on the response channel, one byte
// per beat, with out_last on the final byte. Other packets produce nothing.
// After the last request beat, the first response beat passes through the
// position counter, the read stage and the output register; the block then
// delivers one byte per cycle while the receiver is ready, a rate set by the
// single read port of the header RAM feeding one read stage and one output
// register. Request beats are taken one per cycle, except while a response
// is being read out of the RAM.
// When the receiver stalls, the output register holds its beat and the read
// stage holds its RAM address, so nothing is lost; the next request may start
// as soon as only the final response beat is left waiting.
// Reset clears the byte count and all control state; the header RAM is not
// cleared, since a response only reads entries written by its own request.

module stun_binding_responder
  import sbr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sbr_req_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sbr_resp_t out_data_o
);

  // Request side.
  logic              in_fire;
  logic [CountW-1:0] count_q, count_d;
  logic              match_q, match_d;
  logic              match_cur;
  logic              start;
  logic              ram_we;

  // Response sequencer.
  logic              active_q, active_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              rd_valid_q, rd_valid_d;
  logic [PosW-1:0]   rd_pos_q, rd_pos_d;
  logic              out_valid_q, out_valid_d;
  sbr_resp_t         out_q, out_d;
  logic              v6_q;
  logic [127:0]      addr_q;
  logic [15:0]       port_q;
  logic [PosW-1:0]   last_pos;
  logic              adv;
  logic              issue;
  logic [PosW-1:0]   rd_sel_pos;
  logic [HdrAddrW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // The RAM is never written while a response is being read from it, because
  // requests are held off for as long as reads are in flight.
  assign in_ready_o = !active_q && !rd_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  assign match_cur = ((count_q == '0) ? 1'b1 : match_q)
                   && hdr_byte_ok(count_q, in_data_i.data_byte);
  assign ram_we    = in_fire && (count_q < HdrLenC);
  assign start     = in_fire && in_data_i.last_byte && (count_q >= HdrLastIdx) && match_cur;

  always_comb begin
    count_d = count_q;
    match_d = match_q;
    if (in_fire) begin
      match_d = match_cur;
      if (in_data_i.last_byte) begin
        count_d = '0;
      end else if (count_q != CountMax) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // The output register takes a new beat when it is empty or being drained;
  // the read stage and the position counter move in step with it.
  assign last_pos = v6_q ? PosLastV6 : PosLastV4;
  assign adv      = !out_valid_q || out_ready_i;
  assign issue    = active_q && adv;

  always_comb begin
    active_d    = active_q;
    pos_d       = pos_q;
    rd_valid_d  = rd_valid_q;
    rd_pos_d    = rd_pos_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (start) begin
      active_d = 1'b1;
      pos_d    = '0;
    end else if (issue) begin
      pos_d = pos_q + 1'b1;
      if (pos_q == last_pos) begin
        active_d = 1'b0;
      end
    end
    if (adv) begin
      rd_valid_d  = issue;
      out_valid_d = rd_valid_q;
      if (issue) begin
        rd_pos_d = pos_q;
      end
      if (rd_valid_q) begin
        out_d.out_byte = resp_byte(rd_pos_q, v6_q, addr_q, port_q, ram_rdata);
        out_d.out_last = (rd_pos_q == last_pos);
      end
    end
  end

  // While stalled, the read address stays on the beat in the read stage so
  // that its data is still there when the output register frees up.
  assign rd_sel_pos = issue ? pos_q : rd_pos_q;
  assign ram_raddr  = (rd_sel_pos >= PosMaskTxn) ? HdrAddrW'(rd_sel_pos - PosTxnToMask)
                                                 : rd_sel_pos[HdrAddrW-1:0];

  sbr_ram #(
    .Width(8),
    .Depth(HdrDepth)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q),
    .wdata_i(in_data_i.data_byte),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      match_q     <= 1'b0;
      active_q    <= 1'b0;
      pos_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      match_q     <= match_d;
      active_q    <= active_d;
      pos_q       <= pos_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= rd_pos_d;
    out_q    <= out_d;
    if (start) begin
      v6_q   <= in_data_i.addr_is_v6;
      addr_q <= {in_data_i.src_addr_high, in_data_i.src_addr_low};
      port_q <= in_data_i.src_port;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The header RAM is never written while a response still reads from it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!active_q && !rd_valid_q))
    else $error("header RAM written during response readout");

  // Nothing sits in the read stage behind the final beat of a response; the
  // next request may already be under way, but its first read waits for the
  // output register to drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.out_last) |-> !rd_valid_q)
    else $error("read stage busy behind the final response beat");

  // The position counter never runs past the end of the response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (pos_q <= last_pos))
    else $error("response position beyond its length");

  // A response only begins after the last beat of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(active_q) |-> $past(in_fire && in_data_i.last_byte))
    else $error("response started without a final request beat");

endmodule

// ===== tb/stun_binding_responder_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the STUN Binding responder. Request beats are
// queued up front by the stimulus block, fed to the block by a clocked driver
// and mirrored into a bit-accurate model of the responder at the moment they
// are accepted. A clocked monitor throttles the response channel and compares
// every response beat with the oldest predicted one.

module stun_binding_responder_tb;
  import sbr_pkg::*;

  localparam int unsigned TargetBeats = 260;
  localparam int unsigned QuietBeats  = 40;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned MaxReports  = 10;

  // Ways in which a generated request can be spoilt.
  typedef enum int {
    FaultNone,
    FaultType,
    FaultCookie
  } req_fault_e;

  // One queued request beat. The hold flag makes the driver wait until the
  // response channel has fully drained before this beat is presented.
  typedef struct {
    sbr_req_t beat;
    bit       hold;
  } req_item_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  sbr_req_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  sbr_resp_t out_data_o;

  req_item_t req_beats_q[$];
  sbr_resp_t reply_bytes_q[$];

  // Private copy of the responder's state: the stored header and the
  // saturating byte count of the packet in progress.
  logic [7:0]        hdr_mem [HdrDepth];
  logic [CountW-1:0] hdr_cnt = '0;

  int n_queued_beats   = 0;
  int n_queued_packets = 0;
  int n_predicted      = 0;
  int n_checked        = 0;
  int n_answered       = 0;
  int n_dropped        = 0;
  int n_fail           = 0;
  bit quiet_q          = 1'b0;

  stun_binding_responder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advances the model by one accepted request beat. On the last beat of a
  // well-formed Binding Request the whole reply is appended, byte by byte,
  // to the store of expected response beats.
  function automatic void predict_binding_reply(sbr_req_t beat);
    logic [95:0]  txn;
    logic [223:0] head;
    logic [127:0] addr_x;
    logic [351:0] msg;
    int           n_bytes;
    sbr_resp_t    rsp;
    if (hdr_cnt < HdrLenC) hdr_mem[hdr_cnt] = beat.data_byte;
    if (hdr_cnt < CountMax) hdr_cnt = hdr_cnt + 1'b1;
    if (!beat.last_byte) return;
    // A packet shorter than the header is dropped; the count restarts
    // for the next packet in every case.
    if (hdr_cnt < HdrLenC) begin
      hdr_cnt = '0;
      n_dropped++;
      return;
    end
    hdr_cnt = '0;
    if (({hdr_mem[0], hdr_mem[1]} != ReqType) ||
        ({hdr_mem[4], hdr_mem[5], hdr_mem[6], hdr_mem[7]} != MagicCookie)) begin
      n_dropped++;
      return;
    end
    txn = '0;
    for (int i = 8; i < HdrDepth; i++) txn = {txn[87:0], hdr_mem[i]};
    head = {RespType,
            8'h00, (beat.addr_is_v6 ? MsgLenV6 : MsgLenV4),
            MagicCookie,
            txn,
            AttrXorMapped,
            8'h00, (beat.addr_is_v6 ? AttrLenV6 : AttrLenV4),
            8'h00, (beat.addr_is_v6 ? FamV6 : FamV4),
            beat.src_port ^ MagicCookie[31:16]};
    // The IPv6 mask is the cookie followed by the transaction id.
    addr_x = {beat.src_addr_high, beat.src_addr_low} ^ {MagicCookie, txn};
    msg = beat.addr_is_v6 ? {head, addr_x}
                          : {head, beat.src_addr_low[31:0] ^ MagicCookie, 96'h0};
    n_bytes = beat.addr_is_v6 ? 44 : 32;
    for (int k = 0; k < n_bytes; k++) begin
      rsp.out_byte = msg[351-8*k -: 8];
      rsp.out_last = (k == n_bytes - 1);
      reply_bytes_q.push_back(rsp);
    end
    n_predicted += n_bytes;
    n_answered++;
  endfunction

  // Queues one request packet. The type and cookie bytes are always correct
  // unless a fault is asked for, in which case one bit of them is flipped.
  // A negative fill gives random content elsewhere.
  task automatic queue_request(int len, req_fault_e fault, bit v6, logic [63:0] hi,
                               logic [63:0] lo, logic [15:0] port, int fill, bit hold);
    req_item_t  item;
    int         fault_pos;
    logic [7:0] flip;
    fault_pos = (fault == FaultType)   ? $urandom_range(0, 1) :
                (fault == FaultCookie) ? $urandom_range(4, 7) : -1;
    flip = 8'(1 << $urandom_range(0, 7));
    for (int i = 0; i < len; i++) begin
      item.beat.data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
      case (i)
        0: item.beat.data_byte = ReqType[15:8];
        1: item.beat.data_byte = ReqType[7:0];
        4: item.beat.data_byte = MagicCookie[31:24];
        5: item.beat.data_byte = MagicCookie[23:16];
        6: item.beat.data_byte = MagicCookie[15:8];
        7: item.beat.data_byte = MagicCookie[7:0];
        default: ;
      endcase
      if (i == fault_pos) item.beat.data_byte ^= flip;
      item.beat.last_byte     = (i == len - 1);
      item.beat.addr_is_v6    = v6;
      item.beat.src_addr_high = hi;
      item.beat.src_addr_low  = lo;
      item.beat.src_port      = port;
      item.hold               = hold && (i == 0);
      req_beats_q.push_back(item);
    end
    n_queued_beats += len;
    n_queued_packets++;
  endtask

  // Request driver. A new beat is only presented once the previous one has
  // been taken, so valid and the payload stay put while the block stalls.
  // Idle bursts are inserted at random, except during calm stretches and in
  // the last part of the run.
  int in_gap = 0;
  bit in_calm = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_binding_reply(in_data_i);
      if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
      quiet_q <= (req_beats_q.size() <= QuietBeats);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (req_beats_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (req_beats_q[0].hold && (n_checked != n_predicted)) begin
          // Hold the sender back until every reply byte has been seen.
          in_valid_i <= 1'b0;
        end else if (!quiet_q && !in_calm && ($urandom_range(0, 5) == 0)) begin
          in_gap = $urandom_range(1, 11) - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= req_beats_q[0].beat;
          in_valid_i <= 1'b1;
          req_beats_q.pop_front();
        end
      end
    end
  end

  // Response monitor. It checks each accepted beat against the oldest
  // expected one and drives ready with random stall bursts of its own.
  int out_stall = 0;
  bit out_calm = 1'b0;

  always @(posedge clk_i) begin
    sbr_resp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (reply_bytes_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MaxReports)
            $display("Unexpected response beat: byte %02h last %0b",
                     out_data_o.out_byte, out_data_o.out_last);
        end else begin
          want = reply_bytes_q.pop_front();
          n_checked <= n_checked + 1;
          if ((out_data_o.out_byte !== want.out_byte) ||
              (out_data_o.out_last !== want.out_last)) begin
            n_fail++;
            if (n_fail <= MaxReports)
              $display("Response beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       n_checked, want.out_byte, want.out_last,
                       out_data_o.out_byte, out_data_o.out_last);
          end
        end
      end
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet_q && !out_calm && ($urandom_range(0, 5) == 0)) begin
        out_stall = $urandom_range(1, 11) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int          kind;
    int          len;
    int          n_rand_packets;
    int          waited;
    bit          v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;

    // Directed part: a single-byte packet, which is far too short, then an
    // IPv6 request whose address, port and transaction id are all ones.
    queue_request(1, FaultNone, 1'b1, '1, '1, 16'hFFFF, 8'hFF, 1'b0);
    queue_request(20, FaultNone, 1'b1, '1, '1, 16'hFFFF, 8'hFF, 1'b0);

    // Random part: mostly well-formed requests of both families with random
    // content, some long enough to saturate the count, and the rest spoilt
    // by a wrong type, a wrong cookie or an early last byte.
    n_rand_packets = 0;
    while (n_queued_beats < TargetBeats) begin
      kind = $urandom_range(0, 9);
      v6   = $urandom_range(0, 1);
      hi   = {$urandom, $urandom};
      lo   = {$urandom, $urandom};
      port = 16'($urandom);
      len  = $urandom_range(0, 1) ? 20 : $urandom_range(21, 26);
      case (kind)
        6:       queue_request($urandom_range(30, 40), FaultNone, v6, hi, lo, port, -1,
                               n_rand_packets == 3);
        7:       queue_request(len, FaultType, v6, hi, lo, port, -1, n_rand_packets == 3);
        8:       queue_request(len, FaultCookie, v6, hi, lo, port, -1, n_rand_packets == 3);
        9:       queue_request($urandom_range(1, 19), FaultNone, v6, hi, lo, port, -1,
                               n_rand_packets == 3);
        default: queue_request(len, FaultNone, v6, hi, lo, port, -1, n_rand_packets == 3);
      endcase
      n_rand_packets++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample at the falling edge so that the clocked blocks have settled.
    @(negedge clk_i);
    while ((req_beats_q.size() != 0) || in_valid_i) @(negedge clk_i);
    waited = 0;
    while ((reply_bytes_q.size() != 0) && (waited < DrainLimit)) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (reply_bytes_q.size() != 0) begin
      $display("%0d expected response beats never arrived", reply_bytes_q.size());
      n_fail += reply_bytes_q.size();
    end

    $display("Sent %0d request beats in %0d packets of both families, long, short and spoilt.",
             n_queued_beats, n_queued_packets);
    $display("%0d packets answered, %0d dropped, %0d response beats checked, %0d failures.",
             n_answered, n_dropped, n_checked, n_fail);
    if (n_fail == 0) begin
      $display("stun_binding_responder test passed");
    end else begin
      $display("stun_binding_responder test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("stun_binding_responder test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sbr_pkg.sv
hdl/sbr_ram.sv
hdl/stun_binding_responder.sv
tb/stun_binding_responder_tb.sv
